// File: rtl/simon_pkg.sv
// simon 64/128 shared types, constants and round functions
`timescale 1ns / 1ps
`default_nettype none

package simon_pkg;

    localparam int WORD_BITS  = 32;
    localparam int BLOCK_BITS = 2 * WORD_BITS;
    localparam int KEY_BITS   = 128;
    localparam int KEY_WORDS  = 4;
    localparam int ROUNDS     = 44;
    localparam int RK_AW      = $clog2(ROUNDS);
    localparam int Z_LEN      = 62;
    localparam int Z_AW       = $clog2(Z_LEN);
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 64;

    // sequence z3, first element in the msb
    localparam logic [Z_LEN-1:0] Z_SEQ =
        62'b1101101110_1011000110_0101111000_0001001000_1010011100_1101000011_11;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [RK_AW-1:0]     rk_addr_t;

    typedef enum logic
    {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic     en;
        rk_addr_t addr;
        word_t    data;
    } rk_wr_t;

    function automatic word_t rotl(word_t x, int unsigned s);
        return (x << s) | (x >> (WORD_BITS - s));
    endfunction

    function automatic word_t rotr(word_t x, int unsigned s);
        return (x >> s) | (x << (WORD_BITS - s));
    endfunction

    function automatic word_t round_f(word_t l);
        return (rotl(l, 1) & rotl(l, 8)) ^ rotl(l, 2);
    endfunction

    function automatic word_t key_step(word_t w0, word_t w1, word_t w3, logic z);
        word_t t;
        t = rotr(w3, 3) ^ w1;
        t = t ^ rotr(t, 1);
        return w0 ^ t ^ {{(WORD_BITS-1){1'b0}}, z} ^ ~word_t'(3);
    endfunction

endpackage

`default_nettype wire

// File: rtl/simon_key_expand.sv
// key schedule sequencer, writes one round key per cycle into the key memory
`timescale 1ns / 1ps
`default_nettype none

module simon_key_expand
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [simon_pkg::KEY_BITS-1:0] key,
    output simon_pkg::rk_wr_t                  rk_wr,
    output logic                               busy
);

    logic                                          busy_reg;
    simon_pkg::rk_addr_t                           idx_reg;
    logic [simon_pkg::Z_AW-1:0]                    zidx_reg;
    simon_pkg::word_t                              win_reg [simon_pkg::KEY_WORDS];
    logic [simon_pkg::KEY_WORDS-1:0][simon_pkg::WORD_BITS-1:0] key_words;
    logic                                          is_key_word;
    logic                                          z_bit;
    simon_pkg::word_t                              word_next;

    assign key_words   = key;
    assign is_key_word = idx_reg < simon_pkg::RK_AW'(simon_pkg::KEY_WORDS);
    assign z_bit       = simon_pkg::Z_SEQ[simon_pkg::Z_AW'(simon_pkg::Z_LEN - 1) - zidx_reg];

    always_comb
    begin
        if (is_key_word)
        begin
            word_next = key_words[idx_reg[1:0]];
        end
        else
        begin
            word_next = simon_pkg::key_step(win_reg[0], win_reg[1], win_reg[3], z_bit);
        end
    end

    assign rk_wr.en   = busy_reg && !start;
    assign rk_wr.addr = idx_reg;
    assign rk_wr.data = word_next;
    assign busy       = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            zidx_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            zidx_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (idx_reg == simon_pkg::RK_AW'(simon_pkg::ROUNDS - 1))
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 1'b1;
            if (!is_key_word)
            begin
                zidx_reg <= (zidx_reg == simon_pkg::Z_AW'(simon_pkg::Z_LEN - 1))
                            ? '0 : zidx_reg + 1'b1;
            end
        end
    end

    // window of the last four schedule words
    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= word_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/simon_encrypt_core.sv
// round key memory, feistel round loop and output register
`timescale 1ns / 1ps
`default_nettype none

module simon_encrypt_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire simon_pkg::rk_wr_t               rk_wr,
    input  wire logic                            ks_busy,
    input  wire logic                            plaintext_valid,
    output logic                                 plaintext_stall,
    input  wire logic [simon_pkg::BLOCK_BITS-1:0] plaintext,
    output logic                                 ciphertext_valid,
    input  wire logic                            ciphertext_stall,
    output logic [simon_pkg::BLOCK_BITS-1:0]     ciphertext
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                                  state_reg;
    simon_pkg::rk_addr_t                     cnt_reg;
    simon_pkg::word_t                        l_reg;
    simon_pkg::word_t                        r_reg;
    logic                                    out_valid_reg;
    logic [simon_pkg::BLOCK_BITS-1:0]        ct_reg;
    simon_pkg::word_t                        rk_mem [simon_pkg::ROUNDS];
    simon_pkg::word_t                        rk_q;
    simon_pkg::rk_addr_t                     rd_addr;
    simon_pkg::word_t                        l_next;
    logic                                    last_round;
    logic                                    in_take;
    logic                                    slot_free;
    logic                                    ct_load;

    assign plaintext_stall  = (state_reg != ST_IDLE) || ks_busy;
    assign in_take          = plaintext_valid && !plaintext_stall;
    assign slot_free        = !out_valid_reg || !ciphertext_stall;
    assign last_round       = cnt_reg == simon_pkg::RK_AW'(simon_pkg::ROUNDS - 1);
    assign l_next           = r_reg ^ simon_pkg::round_f(l_reg) ^ rk_q;
    assign ct_load          = slot_free
                              && ((state_reg == ST_RUN && last_round) || state_reg == ST_HOLD);
    assign ciphertext_valid = out_valid_reg;
    assign ciphertext       = ct_reg;

    always_comb
    begin
        if (state_reg == ST_RUN && !last_round)
        begin
            rd_addr = cnt_reg + 1'b1;
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rk_wr.en)
        begin
            rk_mem[rk_wr.addr] <= rk_wr.data;
        end
        rk_q <= rk_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            l_reg         <= '0;
            r_reg         <= '0;
            ct_reg        <= '0;
        end
        else
        begin
            if (ct_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!ciphertext_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        l_reg     <= plaintext[simon_pkg::BLOCK_BITS-1:simon_pkg::WORD_BITS];
                        r_reg     <= plaintext[simon_pkg::WORD_BITS-1:0];
                        cnt_reg   <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (last_round && slot_free)
                    begin
                        ct_reg    <= {l_next, l_reg};
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        l_reg   <= l_next;
                        r_reg   <= l_reg;
                        cnt_reg <= cnt_reg + 1'b1;
                        if (last_round)
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD:
                begin
                    if (slot_free)
                    begin
                        ct_reg    <= {l_reg, r_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/simon_64_128_block_encrypt_unit.sv
// simon 64/128 block encryption unit top level with apb key registers
//
// plaintext channel: plaintext_valid / plaintext_stall / plaintext, a transfer
// happens on a clock edge with valid high and stall low. ciphertext channel
// works the same way with ciphertext_stall driven by the receiver.
// the key is written through apb: key_low at byte address 0, key_high at 8.
// every key write, and reset, starts the key schedule, which writes the 44
// round keys into the key memory one per cycle; plaintext_stall stays high
// until it is done. after reset the schedule of the all-zero key is loaded.
// one block runs 44 rounds, one round per cycle with one key memory read
// per round, and plaintext_stall stays high while a block runs, so a new
// block is taken only after the last one has finished. the result sits in
// an output register, so the next block is taken while a result waits;
// if the receiver stalls past the end of that block, the core holds it
// and waits.
`timescale 1ns / 1ps
`default_nettype none

module simon_64_128_block_encrypt_unit
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [simon_pkg::APB_AW-1:0]    paddr,
    input  wire logic [simon_pkg::APB_DW-1:0]    pwdata,
    output logic [simon_pkg::APB_DW-1:0]         prdata,
    output logic                                 pready,
    input  wire logic                            plaintext_valid,
    output logic                                 plaintext_stall,
    input  wire logic [simon_pkg::BLOCK_BITS-1:0] plaintext,
    output logic                                 ciphertext_valid,
    input  wire logic                            ciphertext_stall,
    output logic [simon_pkg::BLOCK_BITS-1:0]     ciphertext
);

    logic [simon_pkg::APB_DW-1:0] key_low_reg;
    logic [simon_pkg::APB_DW-1:0] key_high_reg;
    logic                         cfg_wr;
    simon_pkg::reg_idx_t          reg_idx;
    simon_pkg::rk_wr_t            rk_wr;
    logic                         ks_busy;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = simon_pkg::reg_idx_t'(paddr[3]);

    always_comb
    begin
        unique case (reg_idx)
            simon_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            simon_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                simon_pkg::REG_KEY_LOW:  key_low_reg  <= pwdata;
                simon_pkg::REG_KEY_HIGH: key_high_reg <= pwdata;
                default:                 key_low_reg  <= key_low_reg;
            endcase
        end
    end

    simon_key_expand u_key_expand
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_wr),
        .key   ({key_high_reg, key_low_reg}),
        .rk_wr (rk_wr),
        .busy  (ks_busy)
    );

    simon_encrypt_core u_encrypt_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .rk_wr            (rk_wr),
        .ks_busy          (ks_busy),
        .plaintext_valid  (plaintext_valid),
        .plaintext_stall  (plaintext_stall),
        .plaintext        (plaintext),
        .ciphertext_valid (ciphertext_valid),
        .ciphertext_stall (ciphertext_stall),
        .ciphertext       (ciphertext)
    );

endmodule

`default_nettype wire
